// File: sv/tce_pkg.sv
// Shared types, constants and the to_half helper function for the texel channel encoder.
// No dependencies; used by tce_lane, texel_channel_encoder_unit and the testbench.
package tce_pkg;

   localparam logic [2:0] KIND_FLOAT = 3'd0;
   localparam logic [2:0] KIND_SNORM = 3'd1;
   localparam logic [2:0] KIND_UNORM = 3'd2;
   localparam logic [2:0] KIND_UINT  = 3'd3;
   localparam logic [2:0] KIND_SINT  = 3'd4;

   localparam logic [1:0] CSR_KIND  = 2'd0;
   localparam logic [1:0] CSR_BITS  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] bits;
   } cfg_type;

   // float32 -> half, round to nearest even, NaN payload kept
   function automatic logic [15:0] to_half(input logic [31:0] x);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [23:0] mm;
      logic [23:0] rem;
      logic [23:0] hlf;
      logic [4:0]  sh;
      logic [10:0] h;
      logic [15:0] r;
      s  = x[31];
      e  = x[30:23];
      m  = x[22:0];
      mm = {1'b1, m};
      sh = 5'd0;
      h = 11'd0;
      rem = 24'd0;
      hlf = 24'd0;
      if (e == 8'hFF) begin
         r = (m != 23'd0) ? {s, 5'h1F, 1'b1, m[21:13]} : {s, 15'h7C00};
      end else if (e >= 8'd143) begin
         r = {s, 15'h7C00};
      end else if (e <= 8'd112) begin
         if (e < 8'd102) begin
            r = {s, 15'd0};
         end else begin
            // sh = 14 - ue = 126 - e, range 14..24
            sh  = 5'(8'd126 - e);
            h   = 11'(mm >> sh);
            hlf = 24'd1 << (sh - 5'd1);
            rem = mm & ((24'd1 << sh) - 24'd1);
            if (rem > hlf || (rem == hlf && h[0])) h = h + 11'd1;
            r = {s, 4'd0, h};
         end
      end else begin
         r = {s, 5'(e - 8'd112), m[22:13]};
         if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && r[0])) r = r + 16'd1;
      end
      return r;
   endfunction

endpackage

// File: sv/tce_lane.sv
// One encode lane: float32 bit pattern to one channel word, two register stages.
// Depends on tce_pkg. Stage 1 clamps and multiplies, stage 2 rounds the product,
// then the word is rounded and saturated combinationally off stage 2.
module tce_lane (
   input  logic             clock,
   input  logic             en,
   input  logic             en2,
   input  tce_pkg::cfg_type cfg,
   input  logic [31:0]      raw,
   output logic [31:0]      word
);

   function automatic logic norm_k(input logic [2:0] k);
      return (k == tce_pkg::KIND_SNORM) || (k == tce_pkg::KIND_UNORM);
   endfunction

   // stage 1 products
   logic [31:0] raw_ff, raw_in;
   logic [2:0]  kind_ff;
   logic [5:0]  bits_ff;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;    // value is zero or NaN, or negative for unorm
   logic        satlo_ff, satlo_in;
   logic        sathi_ff, sathi_in;
   logic [47:0] prod_ff, prod_in;    // magnitude mantissa, or scaled mantissa
   logic [8:0]  sh_ff, sh_in;        // right shift that brings the units bit of the value to bit 0

   logic        s;
   logic [7:0]  e;
   logic [23:0] mm;
   logic        isnan;
   logic        norm;
   logic [16:0] lim;
   logic [31:0] word_in;

   assign s     = raw[31];
   assign e     = raw[30:23];
   assign mm    = {(e != 8'd0), raw[22:0]};
   assign isnan = (e == 8'hFF) && (raw[22:0] != 23'd0);
   assign norm  = (cfg.kind == tce_pkg::KIND_SNORM) || (cfg.kind == tce_pkg::KIND_UNORM);

   always_comb begin
      neg_in = s;
      zero_in = isnan || (raw[30:0] == 31'd0);
      satlo_in = 1'b0;
      sathi_in = 1'b0;
      lim = 17'd0;
      prod_in = 48'd0;
      sh_in = 9'd0;
      if (norm) begin
         if (cfg.kind == tce_pkg::KIND_SNORM)
            lim = (cfg.bits == 6'd8) ? 17'd127 : 17'd32767;
         else
            lim = (cfg.bits == 6'd8) ? 17'd255 : 17'd65535;
         if (cfg.kind == tce_pkg::KIND_UNORM && s) zero_in = 1'b1;
         if (e >= 8'd127 && !isnan) begin
            sathi_in = !s;
            satlo_in = s;
         end else begin
            // single-precision product: mm*lim, then round to 24 bits
            prod_in = 48'(mm) * 48'(lim);
            sh_in = 9'(9'd150 - {1'b0, e});
         end
      end else begin
         prod_in = {24'd0, mm};
         sh_in = 9'(9'd150 - {1'b0, e});
         if (e >= 8'd127 + 8'd33) begin
            sathi_in = !s;
            satlo_in = s;
         end
      end
      raw_in = raw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff   <= raw_in;
         kind_ff  <= cfg.kind;
         bits_ff  <= cfg.bits;
         neg_ff   <= neg_in;
         zero_ff  <= zero_in;
         satlo_ff <= satlo_in;
         sathi_ff <= sathi_in;
         prod_ff  <= prod_in;
         sh_ff    <= sh_in;
      end
   end

   // stage 2: for snorm/unorm, normalize product to 24 significant bits (RNE), like a float multiply
   logic [47:0] p;
   logic [47:0] pr_ff, pr_in;
   logic [5:0]  msb;
   logic [7:0]  drop;
   logic [47:0] rb;
   logic [31:0] raw2_ff;
   logic [2:0]  kind2_ff;
   logic [5:0]  bits2_ff;
   logic        neg2_ff;
   logic        zero2_ff;
   logic        satlo2_ff;
   logic        sathi2_ff;
   logic [8:0]  sh2_ff;

   always_comb begin
      p = prod_ff;
      msb = 6'd0;
      for (int i = 0; i < 48; i++) if (p[i]) msb = 6'(i);
      drop = (norm_k(kind_ff) && msb > 6'd23) ? 8'(msb - 6'd23) : 8'd0;
      rb = (drop != 8'd0) ? (48'd1 << (drop - 8'd1)) : 48'd0;
      pr_in = p;
      if (drop != 8'd0) begin
         pr_in = p >> drop;
         if ((p & ((rb << 1) - 48'd1)) > rb || ((p & ((rb << 1) - 48'd1)) == rb && pr_in[0]))
            pr_in = pr_in + 48'd1;
         pr_in = pr_in << drop;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         pr_ff     <= pr_in;
         raw2_ff   <= raw_ff;
         kind2_ff  <= kind_ff;
         bits2_ff  <= bits_ff;
         neg2_ff   <= neg_ff;
         zero2_ff  <= zero_ff;
         satlo2_ff <= satlo_ff;
         sathi2_ff <= sathi_ff;
         sh2_ff    <= sh_ff;
      end
   end

   // word: round half away, saturate, mask; float kinds pass the raw word or its half
   logic [8:0]  shr;
   logic [47:0] ip;
   logic        rbit;
   logic [33:0] mag;
   logic [33:0] val;
   logic [33:0] maxp;
   logic [33:0] minn;
   logic [5:0]  b;
   logic        sg;
   logic [31:0] mask;

   always_comb begin
      shr = sh2_ff;
      if (shr == 9'd0) begin
         ip = pr_ff;
         rbit = 1'b0;
      end else if (shr > 9'd48) begin
         ip = 48'd0;
         rbit = 1'b0;
      end else begin
         ip = pr_ff >> shr;
         rbit = pr_ff[6'(shr - 9'd1)];
      end
      mag = 34'(ip) + 34'(rbit);
      if (sh2_ff[8]) mag = 34'(pr_ff) << 6'(9'd0 - sh2_ff); // large exponent
      sg = (kind2_ff == tce_pkg::KIND_SNORM) || (kind2_ff == tce_pkg::KIND_SINT);
      if (norm_k(kind2_ff)) begin
         b = (bits2_ff == 6'd8) ? 6'd8 : 6'd16;
         maxp = sg ? ((34'd1 << (b - 6'd1)) - 34'd1) : ((34'd1 << b) - 34'd1);
         minn = maxp;
      end else begin
         b = (bits2_ff == 6'd8) ? 6'd8 : (bits2_ff == 6'd16) ? 6'd16 : 6'd32;
         maxp = sg ? ((34'd1 << (b - 6'd1)) - 34'd1) : ((34'd1 << b) - 34'd1);
         minn = sg ? (34'd1 << (b - 6'd1)) : 34'd0;
      end
      if (sathi2_ff) mag = maxp;
      if (satlo2_ff) mag = minn;
      if (!neg2_ff && mag > maxp) mag = maxp;
      if (neg2_ff && mag > minn) mag = minn;
      if (zero2_ff) mag = 34'd0;
      val = neg2_ff ? (34'd0 - mag) : mag;
      mask = (b == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << b) - 32'd1);
      if (kind2_ff == tce_pkg::KIND_FLOAT)
         word_in = (bits2_ff == 6'd32) ? raw2_ff : {16'd0, tce_pkg::to_half(raw2_ff)};
      else
         word_in = val[31:0] & mask;
   end

   assign word = word_in;

endmodule

// File: sv/tce_merge.sv
// Merge stage: gathers the lane words, zeroes unused channels, holds the result item.
// Depends on nothing beyond its ports.
module tce_merge #(
   parameter int LANES = 4
) (
   input  logic              clock,
   input  logic              load,
   input  logic [LANES-1:0]  keep,
   input  logic [LANES*32-1:0] words,
   output logic [127:0]      data
);

   logic [127:0] data_ff, data_in;

   always_comb begin
      data_in = 128'd0;
      for (int i = 0; i < LANES; i++)
         if (keep[i]) data_in[i*32 +: 32] = words[i*32 +: 32];
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: sv/texel_channel_encoder_unit.sv
// Top level of the texel channel encoder: config registers, lanes, merge, handshake.
// Depends on tce_pkg, tce_lane and tce_merge.
//
//  channel  direction  payload
//  req_     in         tdata: comp_0..comp_3, supplied_count (136 bits)
//  rsp_     out        tdata: word_0..word_3 (128 bits)
//  csr_     in         we, index, wdata (6 bits)
//
// One item per clock sustained while the receiver is ready; each item passes lane stages
// 1 and 2, the merge register and the output register.
// Each stage advances when the stage after it is empty or being emptied.
// Reset clears the valid bits and loads the register reset values.
module texel_channel_encoder_unit #(
   parameter int LANES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // comp_0, comp_1, comp_2, comp_3, supplied_count, 5'b0
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // word_0, word_1, word_2, word_3
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [5:0]   csr_wdata
);

   logic [2:0] kind_ff;
   logic [5:0] bits_ff;
   logic [2:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= tce_pkg::KIND_UNORM;
         bits_ff  <= 6'd8;
         count_ff <= 3'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            tce_pkg::CSR_KIND:  kind_ff  <= csr_wdata[2:0];
            tce_pkg::CSR_BITS:  bits_ff  <= csr_wdata;
            tce_pkg::CSR_COUNT: count_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic adv1, adv2, adv3, ld_o;
   assign ld_o = v3_ff && (!vo_ff || rsp_tready);
   assign adv3 = !v3_ff || ld_o;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (ld_o) vo_ff <= 1'b1;
         else if (rsp_tready) vo_ff <= 1'b0;
      end
   end

   // kind 5..7 act as unsigned integer
   tce_pkg::cfg_type cfg;
   assign cfg.kind = (kind_ff > tce_pkg::KIND_SINT) ? tce_pkg::KIND_UINT : kind_ff;
   assign cfg.bits = bits_ff;

   logic [2:0] sup;
   assign sup = (req_tdata[130:128] > 3'd4) ? 3'd4 : req_tdata[130:128];

   logic [LANES*32-1:0] words;
   logic [LANES-1:0]    keep_in, keep1_ff, keep2_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [31:0] raw;
      assign raw = (3'(g) < sup) ? req_tdata[g*32 +: 32] : 32'd0;
      assign keep_in[g] = 3'(g) < count_ff;
      tce_lane u_lane (
         .clock (clock),
         .en    (adv1),
         .en2   (adv2),
         .cfg   (cfg),
         .raw   (raw),
         .word  (words[g*32 +: 32])
      );
   end

   // lane output is combinational off lane stage 2; stage 3 is the merge register
   always_ff @(posedge clock) begin
      if (adv1) keep1_ff <= keep_in;
      if (adv2) keep2_ff <= keep1_ff;
   end

   logic [127:0] mdata;
   tce_merge #(.LANES(LANES)) u_merge (
      .clock (clock),
      .load  (adv3),
      .keep  (keep2_ff),
      .words (words),
      .data  (mdata)
   );

   logic [127:0] out_ff;
   always_ff @(posedge clock) begin
      if (ld_o) out_ff <= mdata;
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_load: assert property (@(posedge clock) disable iff (reset)
      ld_o |-> v3_ff)
      else $error("output loaded without item");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("empty front stage not ready");

endmodule

// File: tb/texel_channel_encoder_unit_test.sv
// Testbench for texel_channel_encoder_unit: streams texels through a set of format settings
// and checks every word against a bit-exact predictor. Depends on tce_pkg and the RTL.
`timescale 1ns / 100ps

module texel_channel_encoder_unit_test;

   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;
   localparam int NUM_FIXED = 24;
   localparam int NUM_PHASES = 32;
   localparam int PHASE_ITEMS = 60;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [4:0]  pad;
      logic [2:0]  supplied_count;
      logic [31:0] comp_3;
      logic [31:0] comp_2;
      logic [31:0] comp_1;
      logic [31:0] comp_0;
   } texel_in_type;

   typedef struct packed {
      logic [31:0] word_3;
      logic [31:0] word_2;
      logic [31:0] word_1;
      logic [31:0] word_0;
   } texel_words_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;   // comp_0, comp_1, comp_2, comp_3, supplied_count, 5'b0
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // word_0, word_1, word_2, word_3
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = tce_pkg::CSR_KIND;
   logic [5:0]   csr_wdata = '0;

   texel_channel_encoder_unit DUT (.*);

   // format settings as the block should hold them
   logic [2:0] fmt_kind = tce_pkg::KIND_UNORM;
   logic [5:0] fmt_bits = 6'd8;
   logic [2:0] fmt_count = 3'd4;

   texel_in_type    texels_pending[$];
   texel_words_type words_expected[$];
   int items_queued = 0;
   int items_taken = 0;
   int errors = 0;
   int cycles = 0;
   bit req_fired = 0;

   int send_mode = 0;   // 0 back to back, 1 bursts with gaps
   int burst_left = 0;
   int gap_left = 0;
   int recv_mode = 0;   // 0 always ready, 1 random, 2 periodic
   int hold_request = 0;
   int hold_left = 0;
   int recv_tick = 0;

   logic [2:0] fixed_kind[NUM_FIXED] = '{
      tce_pkg::KIND_FLOAT, tce_pkg::KIND_FLOAT, tce_pkg::KIND_FLOAT, tce_pkg::KIND_FLOAT,
      tce_pkg::KIND_SNORM, tce_pkg::KIND_SNORM, tce_pkg::KIND_SNORM, tce_pkg::KIND_UNORM,
      tce_pkg::KIND_UNORM, tce_pkg::KIND_UNORM, tce_pkg::KIND_UINT, tce_pkg::KIND_UINT,
      tce_pkg::KIND_UINT, tce_pkg::KIND_UINT, tce_pkg::KIND_SINT, tce_pkg::KIND_SINT,
      tce_pkg::KIND_SINT, tce_pkg::KIND_SINT, KIND_SPARE_5, KIND_SPARE_6,
      KIND_SPARE_7, tce_pkg::KIND_UNORM, tce_pkg::KIND_SNORM, tce_pkg::KIND_SINT};
   logic [5:0] fixed_bits[NUM_FIXED] = '{
      6'd32, 6'd16, 6'd0, 6'd63, 6'd8, 6'd16, 6'd63, 6'd8, 6'd16, 6'd0, 6'd8, 6'd16,
      6'd32, 6'd24, 6'd8, 6'd16, 6'd32, 6'd63, 6'd32, 6'd8, 6'd16, 6'd8, 6'd8, 6'd1};
   logic [2:0] fixed_count[NUM_FIXED] = '{
      3'd4, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd1, 3'd4, 3'd4, 3'd0, 3'd4, 3'd4,
      3'd4, 3'd7, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd6, 3'd3, 3'd1, 3'd2, 3'd4};

   function automatic logic [15:0] half_of(logic [31:0] x);
      logic [15:0] s;
      int e, ue, sh;
      logic [31:0] m, h, rem, hf;
      s = {x[31], 15'b0};
      e = x[30:23];
      m = {9'b0, x[22:0]};
      ue = e - 112;
      if (e == 255) return (m != 0) ? (s | 16'h7E00 | 16'(m >> 13)) : (s | 16'h7C00);
      if (ue >= 31) return s | 16'h7C00;
      if (ue <= 0) begin
         if (ue < -10) return s;
         m = m | 32'h0080_0000;
         sh = 14 - ue;
         h = m >> sh;
         rem = m & ((32'd1 << sh) - 32'd1);
         hf = 32'd1 << (sh - 1);
         if (rem > hf || (rem == hf && h[0])) h = h + 1;
         return s | 16'(h);
      end
      h = {16'b0, s} | (32'(ue) << 10) | (m >> 13);
      rem = m & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
      return h[15:0];
   endfunction

   // clamp, scale with single-precision rounding of the product, round half away
   function automatic logic [31:0] norm_word(logic [31:0] raw, bit sn, int b);
      logic [63:0] lim, q, keep, rem, hf, t, fr;
      int e, n, s2, sh;
      bit neg;
      lim = sn ? (64'd1 << (b - 1)) - 1 : (64'd1 << b) - 1;
      e = raw[30:23];
      neg = raw[31];
      if (e == 255 && raw[22:0] != 0) return 32'd0;
      if (!sn && neg) return 32'd0;
      if (e >= 127) t = lim;
      else if (e < 100) t = 0;
      else begin
         q = {40'b0, 1'b1, raw[22:0]} * lim;
         n = 0;
         for (int i = 0; i < 64; i++) if (q[i]) n = i;
         if (n > 23) begin
            s2 = n - 23;
            keep = q >> s2;
            rem = q & ((64'd1 << s2) - 1);
            hf = 64'd1 << (s2 - 1);
            if (rem > hf || (rem == hf && keep[0])) keep = keep + 1;
            q = keep << s2;
         end
         sh = 150 - e;
         t = q >> sh;
         fr = q & ((64'd1 << sh) - 1);
         if (fr >= (64'd1 << (sh - 1))) t = t + 1;
      end
      if (neg) t = -t;
      return 32'(t & ((64'd1 << b) - 1));
   endfunction

   function automatic logic [31:0] int_word(logic [31:0] raw, bit sg, int b);
      longint mm, mag, fr, v, lo, hi;
      int e, sh;
      e = raw[30:23];
      if (e == 255 && raw[22:0] != 0) return 32'd0;
      mm = {40'b0, 1'b1, raw[22:0]};
      if (e == 255) mag = 64'd1 << 40;
      else if (e < 126) mag = 0;
      else if (e >= 150) mag = (e - 150 > 16) ? (64'd1 << 40) : (mm << (e - 150));
      else begin
         sh = 150 - e;
         mag = mm >> sh;
         fr = mm & ((64'sd1 << sh) - 1);
         if (fr >= (64'sd1 << (sh - 1))) mag = mag + 1;
      end
      v = raw[31] ? -mag : mag;
      lo = sg ? -(64'sd1 << (b - 1)) : 0;
      hi = sg ? (64'sd1 << (b - 1)) - 1 : (64'sd1 << b) - 1;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return 32'(v & ((64'sd1 << b) - 1));
   endfunction

   function automatic logic [31:0] channel_word(logic [31:0] raw);
      int nb, ib;
      nb = (fmt_bits == 6'd8) ? 8 : 16;
      ib = (fmt_bits == 6'd8) ? 8 : (fmt_bits == 6'd16) ? 16 : 32;
      case (fmt_kind) inside
         tce_pkg::KIND_FLOAT:
            return (fmt_bits == 6'd32) ? raw : {16'b0, half_of(raw)};
         tce_pkg::KIND_SNORM, tce_pkg::KIND_UNORM:
            return norm_word(raw, fmt_kind == tce_pkg::KIND_SNORM, nb);
         default: return int_word(raw, fmt_kind == tce_pkg::KIND_SINT, ib);
      endcase
   endfunction

   function automatic texel_words_type encode_texel(texel_in_type t);
      logic [31:0] comp[4];
      logic [31:0] w[4];
      int sup, ch;
      comp[0] = t.comp_0;
      comp[1] = t.comp_1;
      comp[2] = t.comp_2;
      comp[3] = t.comp_3;
      sup = (t.supplied_count > 4) ? 4 : t.supplied_count;
      ch = (fmt_count > 4) ? 4 : fmt_count;
      for (int i = 0; i < 4; i++)
         w[i] = (i < ch) ? channel_word((i < sup) ? comp[i] : 32'd0) : 32'd0;
      return '{word_3: w[3], word_2: w[2], word_1: w[1], word_0: w[0]};
   endfunction

   function automatic logic [31:0] pick_comp();
      logic [31:0] specials[16] = '{
         32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
         32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF,
         32'h4F80_0000, 32'h4F00_0000, 32'hCF00_0000, 32'h477F_FF00, 32'h3F00_0000,
         32'hBEFF_FFFF};
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 4))
         0: return r;
         1: return {r[31], 8'($urandom_range(90, 165)), r[22:0]};
         2: return {r[31], 8'($urandom_range(126, 160)),
                    r[22:0] & 23'($urandom << $urandom_range(0, 22))};
         3: return specials[$urandom_range(0, 15)];
         default: return {r[31], 8'd126 + 8'(r[30]), r[22:0] & ~23'($urandom_range(0, 1) << 22)};
      endcase
   endfunction

   task automatic queue_texel(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                              logic [31:0] c3, logic [2:0] sup);
      texels_pending.push_back('{pad: 5'b0, supplied_count: sup,
                                 comp_3: c3, comp_2: c2, comp_1: c1, comp_0: c0});
      items_queued++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [5:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tce_pkg::CSR_KIND: fmt_kind = val[2:0];
         tce_pkg::CSR_BITS: fmt_bits = val;
         default: fmt_count = val[2:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (items_taken != items_queued || words_expected.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // items accepted here get their expected words
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         words_expected.push_back(encode_texel(req_tdata));
         items_taken++;
         req_fired = 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (texels_pending.size() > 0) begin
            req_tdata <= texels_pending.pop_front();
            req_tvalid <= 1'b1;
            if (send_mode != 0) begin
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_fired = 0;
   end

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      recv_tick++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (recv_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 99) < 60);
            default: rsp_tready <= (recv_tick % 11) > 3;
         endcase
      end
   end

   always @(posedge clock) begin
      texel_words_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (words_expected.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = words_expected.pop_front();
            if (got.word_0 !== want.word_0) begin
               $error("word_0 expected %h actual %h", want.word_0, got.word_0);
               errors++;
            end
            if (got.word_1 !== want.word_1) begin
               $error("word_1 expected %h actual %h", want.word_1, got.word_1);
               errors++;
            end
            if (got.word_2 !== want.word_2) begin
               $error("word_2 expected %h actual %h", want.word_2, got.word_2);
               errors++;
            end
            if (got.word_3 !== want.word_3) begin
               $error("word_3 expected %h actual %h", want.word_3, got.word_3);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [2:0] k, c;
      logic [5:0] b;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset format (unorm8 x4): extremes, specials, every supplied count
      queue_texel(32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7FC0_0000, 3'd4);
      queue_texel(32'h3F00_0000, 32'h3EFF_FFFF, 32'h7F80_0000, 32'hFF80_0000, 3'd4);
      queue_texel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
      queue_texel(32'h3F7F_FFFF, 32'h3F80_0001, 32'h0000_0001, 32'h8000_0000, 3'd0);
      for (int s = 1; s < 8; s++)
         queue_texel(32'h3F40_0000, 32'h3F40_0000, 32'h3F40_0000, 32'h3F40_0000, 3'(s));
      for (int i = 0; i < 9; i++)
         queue_texel(pick_comp(), pick_comp(), pick_comp(), pick_comp(), 3'(i % 8));
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < NUM_FIXED) begin
            k = fixed_kind[p];
            b = fixed_bits[p];
            c = fixed_count[p];
         end else begin
            k = 3'($urandom_range(0, 7));
            b = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'(8 << $urandom_range(0, 2));
            c = 3'($urandom);
         end
         write_csr(tce_pkg::CSR_KIND, {3'b0, k});
         write_csr(tce_pkg::CSR_BITS, b);
         write_csr(tce_pkg::CSR_COUNT, {3'b0, c});
         send_mode = p % 3 == 0 ? 0 : 1;
         recv_mode = p % 4 == 3 ? 0 : p % 2;
         if (p % 5 == 4) recv_mode = 2;
         @(posedge clock);
         // receiver stalls long enough for the input to back up
         if (p == 3 || p == 17) begin
            send_mode = 0;
            hold_request = LONG_HOLD;
         end
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_texel(pick_comp(), pick_comp(), pick_comp(), pick_comp(), 3'($urandom));
         wait_drained();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/tce_pkg.sv
sv/tce_lane.sv
sv/tce_merge.sv
sv/texel_channel_encoder_unit.sv
tb/texel_channel_encoder_unit_test.sv
